// ----- rtl/rcg_pkg.sv -----
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared types and constants for the rail collapse trigger gate.
// ----------------------------------------------------------------------------
package rcg_pkg;

  localparam int unsigned RAIL_W   = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned BUCKET_W = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_ARM_LEVEL   = 2'd0,
    CFG_DROP_LIMIT  = 2'd1,
    CFG_MUTE_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic [RAIL_W-1:0] ARM_LEVEL_RESET   = 16'd5000;
  localparam logic [RAIL_W-1:0] DROP_LIMIT_RESET  = 16'd500;
  localparam logic [CFG_W-1:0]  MUTE_LENGTH_RESET = 32'd30000000;

  typedef struct packed {
    logic [RAIL_W-1:0] arm_level_mv;
    logic [RAIL_W-1:0] drop_limit_mv;
    logic [CFG_W-1:0]  mute_length_us;
  } cfg_t;

  // One sample as held in the input stage; full marks that the ring had
  // filled once before this sample was stored.
  typedef struct packed {
    logic [RAIL_W-1:0]   rail_mv;
    logic [TIME_W-1:0]   time_us;
    logic                anomaly_seen;
    logic [BUCKET_W-1:0] load_bucket;
    logic                full;
  } sample_t;

  typedef struct packed {
    logic                shutdown_fire;
    logic                anomaly_fire;
    logic                change_fire;
    logic [BUCKET_W-1:0] prior_bucket;
    logic                muted_now;
  } result_t;

endpackage

// ----- rtl/rail_collapse_trigger_gate.sv -----
// ----------------------------------------------------------------------------
// rail_collapse_trigger_gate
// Bus rail collapse detector with a post-shutdown mute window that gates the
// anomaly and load-change triggers.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                                          Direction
//   -------  -----------------------------------------------  ---------
//   in       in_valid/in_ready, rail_mv, time_us,             input
//            anomaly_seen, load_bucket
//   out      out_valid/out_ready, shutdown_fire,              output
//            anomaly_fire, change_fire, prior_bucket,
//            muted_now
//   cfg      cfg_we, cfg_index, cfg_data                      input
//
// One sample can be transferred on every cycle while out_ready is high. The
// transfer edge captures the sample and reads the oldest ring entry in
// parallel, and a later edge loads the decision into the result register
// once that register can take it.
// The rate is set by the single ring read port, which is used once per sample.
// Reset clears the ring pointer, fill count, detector state and handshakes,
// and loads the configuration defaults; the ring contents are not cleared.
// When out_ready is low, the result and input stages hold and in_ready drops
// once both are occupied.
//
module rail_collapse_trigger_gate
  import rcg_pkg::*;
#(
  parameter int unsigned WINDOW = 50
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RAIL_W-1:0]   rail_mv,
  input  logic [TIME_W-1:0]   time_us,
  input  logic                anomaly_seen,
  input  logic [BUCKET_W-1:0] load_bucket,

  output logic                out_valid,
  input  logic                out_ready,
  output logic                shutdown_fire,
  output logic                anomaly_fire,
  output logic                change_fire,
  output logic [BUCKET_W-1:0] prior_bucket,
  output logic                muted_now
);

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);

  // Configuration registers.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_level_mv   <= ARM_LEVEL_RESET;
      cfg.drop_limit_mv  <= DROP_LIMIT_RESET;
      cfg.mute_length_us <= MUTE_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARM_LEVEL:   cfg.arm_level_mv   <= cfg_data[RAIL_W-1:0];
        CFG_DROP_LIMIT:  cfg.drop_limit_mv  <= cfg_data[RAIL_W-1:0];
        CFG_MUTE_LENGTH: cfg.mute_length_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input stage. The ring write of the new sample and the read of the oldest
  // entry happen on the same transfer edge, at different addresses, so the
  // read data lines up with the sample held in this stage.
  logic              accept;
  logic              s1_valid;
  sample_t           s1_item;
  logic              item_ready;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;
  logic [FILL_W-1:0] fill;
  logic              ring_full;
  logic [RAIL_W-1:0] oldest;
  result_t           res;

  assign in_ready  = !s1_valid || item_ready;
  assign accept    = in_valid && in_ready;
  assign ring_full = (fill == FILL_W'(WINDOW));
  // The oldest entry is the one the following sample will overwrite.
  assign ptr_next  = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ptr      <= '0;
      fill     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        ptr      <= ptr_next;
        if (!ring_full) begin
          fill <= fill + FILL_W'(1);
        end
      end else if (item_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.rail_mv      <= rail_mv;
      s1_item.time_us      <= time_us;
      s1_item.anomaly_seen <= anomaly_seen;
      s1_item.load_bucket  <= load_bucket;
      s1_item.full         <= ring_full;
    end
  end

  rcg_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr),
    .wdata (rail_mv),
    .re    (accept),
    .raddr (ptr_next),
    .rdata (oldest)
  );

  rcg_gate u_gate (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s1_valid),
    .item       (s1_item),
    .oldest     (oldest),
    .item_ready (item_ready),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign shutdown_fire = res.shutdown_fire;
  assign anomaly_fire  = res.anomaly_fire;
  assign change_fire   = res.change_fire;
  assign prior_bucket  = res.prior_bucket;
  assign muted_now     = res.muted_now;

  a_ptr_in_range : assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(WINDOW - 1) && fill <= FILL_W'(WINDOW))
    else $error("ring pointer or fill count out of range");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !item_ready |=> s1_valid && $stable(s1_item) && $stable(oldest))
    else $error("input stage changed while stalled");

  a_fill_only_on_transfer : assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(fill) && $stable(ptr))
    else $error("ring bookkeeping moved without a transfer");

endmodule

// ----- rtl/rcg_ring.sv -----
// ----------------------------------------------------------------------------
// rcg_ring
// Sample history memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcg_ring
  import rcg_pkg::*;
#(
  parameter int unsigned DEPTH  = 50,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [RAIL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [RAIL_W-1:0] rdata
);

  logic [RAIL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rcg_gate.sv -----
// ----------------------------------------------------------------------------
// rcg_gate
// Collapse decision, mute window and trigger gating, with the result register.
// ----------------------------------------------------------------------------
module rcg_gate
  import rcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  sample_t           item,
  input  logic [RAIL_W-1:0] oldest,
  output logic              item_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  logic                armed;
  logic [TIME_W-1:0]   mute_end;
  logic [BUCKET_W-1:0] last_bucket;
  logic                seen_first;

  logic                armed_next;
  logic [TIME_W-1:0]   mute_end_next;
  logic                advance;
  logic                armed_now;
  logic [RAIL_W-1:0]   drop;
  logic                fire;
  logic [TIME_W:0]     end_sum;
  logic [TIME_W-1:0]   end_sat;
  logic                muted;
  result_t             res_next;

  assign item_ready = !res_valid || res_ready;
  assign advance    = item_valid && item_ready;

  always_comb begin
    // Arming only counts once the ring holds a full window.
    armed_now = armed || (item.full && (item.rail_mv >= cfg.arm_level_mv));
    drop      = oldest - item.rail_mv;
    fire      = item.full && armed_now && (oldest > item.rail_mv) &&
                (drop > cfg.drop_limit_mv);

    end_sum = {1'b0, item.time_us} + (TIME_W+1)'(cfg.mute_length_us);
    end_sat = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

    armed_next    = fire ? 1'b0 : armed_now;
    mute_end_next = fire ? end_sat : mute_end;
    muted         = item.time_us < mute_end_next;

    res_next.shutdown_fire = fire;
    res_next.anomaly_fire  = item.anomaly_seen && !muted;
    res_next.change_fire   = seen_first && (item.load_bucket != last_bucket) && !muted;
    res_next.prior_bucket  = last_bucket;
    res_next.muted_now     = muted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      armed       <= 1'b0;
      mute_end    <= '0;
      last_bucket <= '0;
      seen_first  <= 1'b0;
    end else if (advance) begin
      res_valid   <= 1'b1;
      armed       <= armed_next;
      mute_end    <= mute_end_next;
      last_bucket <= item.load_bucket;
      seen_first  <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  a_fire_disarms : assert property (@(posedge clk) disable iff (rst)
    advance && fire |=> !armed)
    else $error("detector still armed after a shutdown");

  a_no_fire_while_filling : assert property (@(posedge clk) disable iff (rst)
    advance && !item.full |=> !res.shutdown_fire)
    else $error("shutdown reported before the ring filled");

  a_first_no_change : assert property (@(posedge clk) disable iff (rst)
    advance && !seen_first |=> !res.change_fire && res.prior_bucket == '0)
    else $error("load change reported on the first sample");

endmodule
